>>> hw/rtl/rtp_pkg.sv
package rtp_pkg;

  localparam int unsigned AccW = 64;
  localparam int unsigned ProdW = AccW + 5;

  localparam logic [7:0] ChrPlus  = 8'h2B;
  localparam logic [7:0] ChrMinus = 8'h2D;
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrNine  = 8'h39;
  localparam logic [7:0] ChrLowA  = 8'h61;
  localparam logic [7:0] ChrLowF  = 8'h66;
  localparam logic [7:0] ChrUpA   = 8'h41;
  localparam logic [7:0] ChrUpF   = 8'h46;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrTab   = 8'h09;
  localparam logic [7:0] ChrCr    = 8'h0D;

  localparam logic [4:0] RadixDefault = 5'd10;
  localparam logic [4:0] RadixMin     = 5'd2;
  localparam logic [4:0] RadixMax     = 5'd16;
  localparam logic [2:0] TypeDefault  = 3'd3;

  typedef enum logic [0:0] {
    REG_RADIX       = 1'b0,
    REG_RESULT_TYPE = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DIGIT = 2'd1,
    ST_RANGE     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_e;

  // one classified byte as it travels from front to back
  typedef struct packed {
    logic       blank;
    logic       plus;
    logic       minus;
    logic       digit;
    logic       bad;
    logic [3:0] dval;
    logic [4:0] base;
    logic [2:0] rtype;
  } item_t;

  // bits at and above the type width
  function automatic logic [63:0] high_mask(input logic [1:0] sel);
    logic [63:0] m;
    unique case (sel)
      2'd0: m = ~64'h0000_0000_0000_00FF;
      2'd1: m = ~64'h0000_0000_0000_FFFF;
      2'd2: m = ~64'h0000_0000_FFFF_FFFF;
      default: m = 64'h0;
    endcase
    return m;
  endfunction

  // magnitude of the most negative value of the type
  function automatic logic [63:0] min_mag(input logic [1:0] sel);
    logic [63:0] m;
    unique case (sel)
      2'd0: m = 64'h0000_0000_0000_0080;
      2'd1: m = 64'h0000_0000_0000_8000;
      2'd2: m = 64'h0000_0000_8000_0000;
      default: m = 64'h8000_0000_0000_0000;
    endcase
    return m;
  endfunction

endpackage

>>> hw/rtl/rtp_front.sv
module rtp_front import rtp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [0:0] cfg_index_i,
  input  logic [4:0] cfg_data_i,
  input  logic [7:0] char_in_i,
  output item_t      item_o
);

  logic [4:0] radix_q;
  logic [2:0] rtype_q;
  logic [4:0] base;
  logic       is_hex;
  logic [3:0] dval;
  logic [7:0] off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixDefault;
      rtype_q <= TypeDefault;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_RADIX:       radix_q <= cfg_data_i;
        REG_RESULT_TYPE: rtype_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign base = (radix_q >= RadixMin && radix_q <= RadixMax) ? radix_q : RadixDefault;

  always_comb begin
    is_hex = 1'b1;
    off    = 8'h00;
    priority if (char_in_i >= ChrZero && char_in_i <= ChrNine) begin
      off = char_in_i - ChrZero;
    end else if (char_in_i >= ChrLowA && char_in_i <= ChrLowF) begin
      off = char_in_i - ChrLowA + 8'd10;
    end else if (char_in_i >= ChrUpA && char_in_i <= ChrUpF) begin
      off = char_in_i - ChrUpA + 8'd10;
    end else begin
      is_hex = 1'b0;
    end
    dval = off[3:0];
  end

  always_comb begin
    item_o.blank = (char_in_i == ChrSpace) || (char_in_i >= ChrTab && char_in_i <= ChrCr);
    item_o.plus  = (char_in_i == ChrPlus);
    item_o.minus = (char_in_i == ChrMinus);
    item_o.digit = is_hex && ({1'b0, dval} < base);
    // decimal digit the radix cannot hold
    item_o.bad   = is_hex && (dval < 4'd10) && ({1'b0, dval} >= base);
    item_o.dval  = dval;
    item_o.base  = base;
    item_o.rtype = rtype_q;
  end

endmodule

>>> hw/rtl/rtp_fifo.sv
module rtp_fifo import rtp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t data_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = count_q[1];
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

>>> hw/rtl/rtp_back.sv
module rtp_back import rtp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  item_t       item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] number_o,
  output logic [1:0]  status_o
);

  phase_e            phase_q, phase_d;
  logic              minus_q, minus_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;
  logic [63:0]       number_q, number_d;
  logic [1:0]        status_q, status_d;

  logic              take;
  logic              is_signed;
  logic [ProdW-1:0]  prod;
  logic [63:0]       v;
  logic              over;
  logic [63:0]       fin_num;
  status_e           fin_st;

  assign take      = valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o     = take;
  assign is_signed = item_i.rtype[2];

  assign prod = ({{(ProdW-AccW){1'b0}}, acc_q} * ProdW'(item_i.base))
              + ProdW'(item_i.dval);

  assign v = 64'(acc_q);

  // range check of the finished magnitude
  always_comb begin
    if (!is_signed) begin
      over = |(v & high_mask(item_i.rtype[1:0]));
    end else if (minus_q) begin
      over = v > min_mag(item_i.rtype[1:0]);
    end else begin
      over = v >= min_mag(item_i.rtype[1:0]);
    end
    fin_num = 64'h0;
    fin_st  = ST_OK;
    if (ovf_q || over) begin
      fin_st = ST_RANGE;
    end else if (is_signed && minus_q) begin
      fin_num = 64'h0 - v;
    end else begin
      fin_num = v;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    minus_d     = minus_q;
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    number_d    = number_q;
    status_d    = status_q;
    if (take) begin
      priority if (phase_q != PH_DIGITS && item_i.blank) begin
        // whitespace before the digits is dropped
      end else if (phase_q == PH_LEAD && is_signed && (item_i.plus || item_i.minus)) begin
        minus_d = item_i.minus;
        phase_d = PH_SIGN;
      end else if (item_i.bad) begin
        out_valid_d = 1'b1;
        number_d    = 64'h0;
        status_d    = ST_BAD_DIGIT;
        phase_d     = PH_LEAD;
        minus_d     = 1'b0;
        acc_d       = '0;
        ovf_d       = 1'b0;
      end else if (item_i.digit) begin
        phase_d = PH_DIGITS;
        if (!ovf_q) begin
          if (|prod[ProdW-1:AccW]) begin
            ovf_d = 1'b1;
          end else begin
            acc_d = prod[AccW-1:0];
          end
        end
      end else begin
        out_valid_d = 1'b1;
        number_d    = fin_num;
        status_d    = fin_st;
        phase_d     = PH_LEAD;
        minus_d     = 1'b0;
        acc_d       = '0;
        ovf_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      minus_q     <= 1'b0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      minus_q     <= minus_d;
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    number_q <= number_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign number_o    = number_q;
  assign status_o    = status_q;

endmodule

>>> hw/rtl/radix_integer_text_parser_top.sv
// a result is registered in the back end as it takes the byte that ends the number from the queue
// a stalled result holds back the bytes still waiting in the queue behind it
// throughput: one byte per cycle while the output is not stalled
// a two-entry queue between classifier and back end absorbs output stalls
// reset: radix 10, result type unsigned 64 bit, parse state cleared, queue and output empty
module radix_integer_text_parser_top import rtp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] number_o,
  output logic [1:0]  status_o
);

  item_t fr_item;
  item_t q_item;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  logic  push;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign push        = in_valid_i && !q_full;

  rtp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .char_in_i   (char_in_i),
    .item_o      (fr_item)
  );

  rtp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_item)
  );

  rtp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .number_o    (number_o),
    .status_o    (status_o)
  );

endmodule
